// ----- rtl/dsi_pkg.sv -----
// shared types, widths and coefficient tables for the doped silica index block
package dsi_pkg;

   // payload and configuration widths
   localparam int W_W       = 32;
   localparam int IDX_W     = 32;
   localparam int FRAC_W    = 17;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GE_FRAC = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_F_FRAC  = 2'd1;

   // coefficient blend unit
   localparam int COEF_N    = 6;
   localparam int TERM_N    = 3;
   localparam int TAB_W     = 25;
   localparam int ACC_W     = 43;
   localparam int MAG_W     = 40;
   localparam int DVD_W     = 49;
   localparam int STEP_W    = 2;
   localparam int QW        = 36;
   localparam logic [DVD_W-1:0]  ROUND_BIAS = 49'd7812;
   // ceil(2^63 / 15625), exact quotient for every dividend below 2^49
   localparam int DIV_RECIP_W  = 50;
   localparam int DIV_RECIP_SH = 63;
   localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 50'd590295810358706;

   // multiplier
   localparam int MUL_W   = 56;
   localparam int HALF_W  = 28;
   localparam int PROD_W  = 112;
   localparam int MUL_LAT = 3;

   // term lane
   localparam int P_W    = 56;
   localparam int R_W    = 46;
   localparam int DEN_W  = 62;
   localparam int NUM_W  = 66;
   localparam int TQ_W   = 61;
   localparam int NHI_W  = NUM_W - TQ_W;
   localparam int TERM_W = 64;
   localparam logic [49:0] KR_Q60 = 50'd612067286650000;

   // root unit
   localparam int X_W         = 64;
   localparam int ROOT_W      = 32;
   localparam int SQ_REM_W    = 34;
   localparam int SQRT_STEPS  = 32;

   // latencies, counted in register stages
   localparam int TERM_LAT = 3 * MUL_LAT + 2 + TQ_W + 1;
   localparam int SQRT_LAT = SQRT_STEPS + 1;
   localparam int PIPE_LAT = TERM_LAT + 3 + SQRT_LAT + 1;

   typedef struct packed {
      logic [W_W-1:0] angular_frequency;
      logic           last_sample_in;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] refractive_index;
      logic             index_invalid;
      logic             last_sample_out;
   } rsp_type;

   typedef struct packed {
      logic          neg;
      logic [QW-1:0] mag;
   } coef_type;

   typedef struct packed {
      logic invalid;
      logic saturate;
   } root_tag_type;

   // entries 0..2 are strengths, 3..5 resonance wavelengths, units of 1e-6
   function automatic logic signed [TAB_W-1:0] tab_base(input logic [2:0] k);
      case (k)
         3'd0:    tab_base = 25'sd697668;
         3'd1:    tab_base = 25'sd407339;
         3'd2:    tab_base = 25'sd889883;
         3'd3:    tab_base = 25'sd70861;
         3'd4:    tab_base = 25'sd113600;
         3'd5:    tab_base = 25'sd9784231;
         default: tab_base = '0;
      endcase
   endfunction

   function automatic logic signed [TAB_W-1:0] tab_ge(input logic [2:0] k);
      case (k)
         3'd0:    tab_ge = 25'sd31510;
         3'd1:    tab_ge = 25'sd267302;
         3'd2:    tab_ge = -25'sd12950;
         3'd3:    tab_ge = 25'sd1677;
         3'd4:    tab_ge = 25'sd32138;
         3'd5:    tab_ge = 25'sd318034;
         default: tab_ge = '0;
      endcase
   endfunction

   function automatic logic signed [TAB_W-1:0] tab_f(input logic [2:0] k);
      case (k)
         3'd0:    tab_f = -25'sd3234366;
         3'd1:    tab_f = 25'sd164911;
         3'd2:    tab_f = 25'sd1369490;
         3'd3:    tab_f = -25'sd1108703;
         3'd4:    tab_f = 25'sd752919;
         3'd5:    tab_f = 25'sd2906858;
         default: tab_f = '0;
      endcase
   endfunction

endpackage

// ----- rtl/dsi_mul.sv -----
// three-stage 56x56 unsigned multiplier built from 28x28 partial products
module dsi_mul (
   input  logic                       clock,
   input  logic [dsi_pkg::MUL_W-1:0]  a_in,
   input  logic [dsi_pkg::MUL_W-1:0]  b_in,
   output logic [dsi_pkg::PROD_W-1:0] prod
);
   import dsi_pkg::*;

   logic [2*HALF_W-1:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [2*HALF_W-1:0] ll2_ff, hh2_ff;
   logic [2*HALF_W:0]   mid_ff;
   logic [PROD_W-1:0]   prod_ff;

   always_ff @(posedge clock) begin
      ll_ff   <= a_in[HALF_W-1:0] * b_in[HALF_W-1:0];
      lh_ff   <= a_in[HALF_W-1:0] * b_in[MUL_W-1:HALF_W];
      hl_ff   <= a_in[MUL_W-1:HALF_W] * b_in[HALF_W-1:0];
      hh_ff   <= a_in[MUL_W-1:HALF_W] * b_in[MUL_W-1:HALF_W];
      mid_ff  <= {1'b0, lh_ff} + {1'b0, hl_ff};
      ll2_ff  <= ll_ff;
      hh2_ff  <= hh_ff;
      prod_ff <= {hh2_ff, ll2_ff}
               + {{(PROD_W-2*HALF_W-1-HALF_W){1'b0}}, mid_ff, {HALF_W{1'b0}}};
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/dsi_blend.sv -----
// configuration registers and sequential dopant blend of the six coefficients
module dsi_blend (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [dsi_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [dsi_pkg::FRAC_W-1:0]             csr_wdata,
   output logic                                   busy,
   output dsi_pkg::coef_type [dsi_pkg::COEF_N-1:0] coefs
);
   import dsi_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MAC_GE = 3'd1;
   localparam logic [2:0] ST_MAC_F  = 3'd2;
   localparam logic [2:0] ST_LOAD   = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;

   logic [2:0]               state_ff;
   logic [2:0]               idx_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [FRAC_W-1:0]        ge_frac_ff, f_frac_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [DVD_W-1:0]         dvd_ff;
   logic                     neg_ff;
   coef_type                 coef_ff [COEF_N];

   logic signed [FRAC_W:0]   ge_s, f_s;
   logic signed [ACC_W-1:0]  base_ext, prod_ge, prod_f, acc_abs;
   logic [DVD_W-1:0]         dvd_in;
   logic [PROD_W-1:0]        recip_prod;
   logic [QW-1:0]            quo;
   logic                     csr_hit, last_step;

   assign ge_s     = $signed({1'b0, ge_frac_ff});
   assign f_s      = $signed({1'b0, f_frac_ff});
   assign base_ext = ACC_W'(tab_base(idx_ff));
   assign prod_ge  = ge_s * tab_ge(idx_ff);
   assign prod_f   = f_s * tab_f(idx_ff);
   assign acc_abs  = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
   // floor((|s| * 2^14 + 5e5) / 1e6) == floor((|s| * 2^8 + 7812) / 15625)
   assign dvd_in   = {1'b0, acc_abs[MAG_W-1:0], 8'b0} + ROUND_BIAS;
   assign csr_hit  = csr_write_en && (csr_index == CSR_GE_FRAC || csr_index == CSR_F_FRAC);
   assign last_step = step_ff == STEP_W'(MUL_LAT);

   // divide by 15625 as a multiply by its scaled reciprocal
   dsi_mul u_recip (
      .clock (clock),
      .a_in  ({{(MUL_W-DVD_W){1'b0}}, dvd_ff}),
      .b_in  ({{(MUL_W-DIV_RECIP_W){1'b0}}, DIV_RECIP}),
      .prod  (recip_prod)
   );
   assign quo = recip_prod[DIV_RECIP_SH+QW-1:DIV_RECIP_SH];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_MAC_GE;
         idx_ff     <= '0;
         step_ff    <= '0;
         ge_frac_ff <= '0;
         f_frac_ff  <= '0;
      end else if (csr_hit) begin
         if (csr_index == CSR_GE_FRAC) begin
            ge_frac_ff <= csr_wdata;
         end else begin
            f_frac_ff <= csr_wdata;
         end
         state_ff <= ST_MAC_GE;
         idx_ff   <= '0;
      end else begin
         case (state_ff)
            ST_MAC_GE: state_ff <= ST_MAC_F;
            ST_MAC_F:  state_ff <= ST_LOAD;
            ST_LOAD: begin
               step_ff  <= '0;
               state_ff <= ST_DIV;
            end
            // wait out the multiplier, then take the quotient
            ST_DIV: begin
               step_ff <= step_ff + 1'b1;
               if (last_step) begin
                  if (idx_ff == 3'(COEF_N - 1)) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= ST_MAC_GE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_MAC_GE: acc_ff <= (base_ext <<< 16) + prod_ge;
         ST_MAC_F:  acc_ff <= acc_ff + prod_f;
         ST_LOAD: begin
            dvd_ff <= dvd_in;
            neg_ff <= acc_ff[ACC_W-1];
         end
         ST_DIV: begin
            if (last_step) begin
               coef_ff[idx_ff] <= '{neg: neg_ff, mag: quo};
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      for (int k = 0; k < COEF_N; k++) begin
         coefs[k] = coef_ff[k];
      end
   end

   assign busy = state_ff != ST_IDLE;

endmodule

// ----- rtl/dsi_term.sv -----
// one Sellmeier term: ratio, squared ratio, denominator and pipelined divide
module dsi_term (
   input  logic                              clock,
   input  logic [dsi_pkg::W_W-1:0]           w,
   input  logic [dsi_pkg::QW-1:0]            l_mag,
   input  dsi_pkg::coef_type                 b_coef,
   output logic signed [dsi_pkg::TERM_W-1:0] term,
   output logic                              den_zero
);
   import dsi_pkg::*;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [TQ_W-1:0]  num;
      logic [DEN_W-1:0] den;
      logic [TQ_W-1:0]  quo;
      logic             ovf;
      logic             zero;
      logic             neg;
   } div_type;

   localparam logic [DEN_W-1:0] ONE_Q30    = DEN_W'(64'd1073741824);
   localparam logic [TQ_W-1:0]  TERM_CLAMP = {1'b1, {(TQ_W-1){1'b0}}};

   function automatic div_type div_step(input div_type s, input logic [5:0] b);
      logic [DEN_W:0] rem_sh;
      logic           ge;
      div_type        n;
      rem_sh = {s.rem, s.num[b]};
      ge     = rem_sh >= {1'b0, s.den};
      n      = s;
      n.rem  = ge ? DEN_W'(rem_sh - {1'b0, s.den}) : rem_sh[DEN_W-1:0];
      n.quo[b] = ge;
      return n;
   endfunction

   logic [PROD_W-1:0] prod1, prod2, prod3;
   logic [P_W-1:0]    p;
   logic [R_W-1:0]    r;
   logic [DEN_W-1:0]  q;
   logic [DEN_W-1:0]  den_ff, den2_ff;
   logic              dzero_ff, dneg_ff, zero2_ff, neg2_ff;
   logic [NUM_W-1:0]  num_ff;
   div_type           st_init;
   div_type           st_ff [TQ_W];
   logic [TQ_W-1:0]   t_mag;
   logic signed [TERM_W-1:0] term_ff;
   logic              zero_out_ff;
   div_type           st_last;

   dsi_mul u_mul_p (
      .clock (clock),
      .a_in  ({{(MUL_W-W_W){1'b0}}, w}),
      .b_in  ({{(MUL_W-QW){1'b0}}, l_mag}),
      .prod  (prod1)
   );
   assign p = prod1[P_W+11:12];

   dsi_mul u_mul_r (
      .clock (clock),
      .a_in  (p),
      .b_in  ({{(MUL_W-50){1'b0}}, KR_Q60}),
      .prod  (prod2)
   );
   assign r = prod2[R_W+59:60];

   dsi_mul u_mul_q (
      .clock (clock),
      .a_in  ({{(MUL_W-R_W){1'b0}}, r}),
      .b_in  ({{(MUL_W-R_W){1'b0}}, r}),
      .prod  (prod3)
   );
   assign q = prod3[DEN_W+29:30];

   always_ff @(posedge clock) begin
      dzero_ff <= q == ONE_Q30;
      dneg_ff  <= q > ONE_Q30;
      den_ff   <= (q > ONE_Q30) ? q - ONE_Q30 : ONE_Q30 - q;
      // numerator carries the half-divisor for round half up
      num_ff   <= {b_coef.mag, 30'b0} + {{(NUM_W-DEN_W+1){1'b0}}, den_ff[DEN_W-1:1]};
      den2_ff  <= den_ff;
      zero2_ff <= dzero_ff;
      neg2_ff  <= b_coef.neg ^ dneg_ff;
   end

   always_comb begin
      st_init.num  = num_ff[TQ_W-1:0];
      st_init.den  = den2_ff;
      st_init.quo  = '0;
      st_init.zero = zero2_ff;
      st_init.neg  = neg2_ff;
      st_init.ovf  = {{(DEN_W-NHI_W){1'b0}}, num_ff[NUM_W-1:TQ_W]} >= den2_ff;
      st_init.rem  = st_init.ovf ? '0 : {{(DEN_W-NHI_W){1'b0}}, num_ff[NUM_W-1:TQ_W]};
   end

   // one quotient bit per stage, most significant first
   always_ff @(posedge clock) begin
      for (int j = 0; j < TQ_W; j++) begin
         st_ff[j] <= div_step((j == 0) ? st_init : st_ff[j-1], 6'(TQ_W - 1 - j));
      end
   end

   assign st_last = st_ff[TQ_W-1];
   assign t_mag   = (st_last.ovf || st_last.quo > TERM_CLAMP) ? TERM_CLAMP : st_last.quo;

   always_ff @(posedge clock) begin
      zero_out_ff <= st_last.zero;
      if (st_last.zero) begin
         term_ff <= '0;
      end else if (st_last.neg) begin
         term_ff <= -$signed({{(TERM_W-TQ_W){1'b0}}, t_mag});
      end else begin
         term_ff <= $signed({{(TERM_W-TQ_W){1'b0}}, t_mag});
      end
   end

   assign term     = term_ff;
   assign den_zero = zero_out_ff;

endmodule

// ----- rtl/dsi_sqrt.sv -----
// pipelined integer square root, one result bit per stage, rounded to nearest
module dsi_sqrt (
   input  logic                         clock,
   input  logic [dsi_pkg::X_W-1:0]      x,
   input  dsi_pkg::root_tag_type        tag_in,
   output logic [dsi_pkg::ROOT_W-1:0]   root,
   output dsi_pkg::root_tag_type        tag_out
);
   import dsi_pkg::*;

   typedef struct packed {
      logic [X_W-1:0]      x;
      logic [ROOT_W-1:0]   root;
      logic [SQ_REM_W-1:0] rem;
      root_tag_type        tag;
   } sq_type;

   function automatic sq_type sq_step(input sq_type s, input logic [4:0] i);
      logic [X_W-1:0]        sh;
      logic [SQ_REM_W+1:0]   rem_sh, trial;
      logic                  ge;
      sq_type                n;
      sh     = s.x >> {i, 1'b0};
      rem_sh = {s.rem, sh[1:0]};
      trial  = {2'b0, s.root, 2'b01};
      ge     = rem_sh >= trial;
      n      = s;
      n.rem  = ge ? SQ_REM_W'(rem_sh - trial) : rem_sh[SQ_REM_W-1:0];
      n.root = {s.root[ROOT_W-2:0], ge};
      return n;
   endfunction

   sq_type            st_init;
   sq_type            st_ff [SQRT_STEPS];
   sq_type            st_last;
   logic [ROOT_W:0]   rnd;
   logic [ROOT_W-1:0] root_ff;
   root_tag_type      tag_ff;

   assign st_init = '{x: x, root: '0, rem: '0, tag: tag_in};

   always_ff @(posedge clock) begin
      for (int j = 0; j < SQRT_STEPS; j++) begin
         st_ff[j] <= sq_step((j == 0) ? st_init : st_ff[j-1], 5'(SQRT_STEPS - 1 - j));
      end
   end

   assign st_last = st_ff[SQRT_STEPS-1];
   // remainder above the root means the true root lies past the half point
   assign rnd = {1'b0, st_last.root}
              + {{ROOT_W{1'b0}}, st_last.rem > {{(SQ_REM_W-ROOT_W){1'b0}}, st_last.root}};

   always_ff @(posedge clock) begin
      root_ff <= rnd[ROOT_W] ? '1 : rnd[ROOT_W-1:0];
      tag_ff  <= st_last.tag;
   end

   assign root    = root_ff;
   assign tag_out = tag_ff;

endmodule

// ----- rtl/doped_silica_sellmeier_index.sv -----
// top level: refractive index of germanium and fluorine doped silica
// One sample enters per clock whenever busy is low and leaves as a one-cycle
// rsp_strobe pulse; results keep input order and the receiver cannot stall
// them. The depth is set by the three-term lanes (three 3-stage multipliers,
// then a 61-stage restoring divider per term) and the 32-stage square root.
// busy is high only while the coefficient blend unit recomputes the six
// strengths and resonance wavelengths: after reset and after each write to
// either dopant fraction, each coefficient waiting on its three-stage
// reciprocal multiply.
module doped_silica_sellmeier_index (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  dsi_pkg::req_type              req_payload,
   output logic                          rsp_strobe,
   output dsi_pkg::rsp_type              rsp_payload,
   input  logic                          csr_write_en,
   input  logic [dsi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dsi_pkg::FRAC_W-1:0]    csr_wdata
);
   import dsi_pkg::*;

   localparam logic signed [TERM_W-1:0] ONE_Q30 = 64'sd1073741824;
   localparam logic signed [TERM_W-1:0] SAT_LIM = 64'sd17179869184;

   coef_type [COEF_N-1:0]     coefs;
   logic                      accept;
   logic [W_W-1:0]            w_ff;
   // valid and last-sample mark travel beside the datapath
   logic [PIPE_LAT:0]         vld_ff;
   logic [PIPE_LAT-1:0]       last_ff;
   logic signed [TERM_W-1:0]  term [TERM_N];
   logic [TERM_N-1:0]         dzero;
   logic signed [TERM_W-1:0]  s01_ff, t2p_ff, er_ff;
   logic                      zero1_ff, zero2_ff;
   logic [X_W-1:0]            x_ff;
   root_tag_type              tag_ff, tag_out;
   logic [ROOT_W-1:0]         root;
   rsp_type                   rsp_ff;

   // coefficient blend and configuration registers
   dsi_blend u_blend (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .busy         (busy),
      .coefs        (coefs)
   );

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_LAT-1:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= req_payload.angular_frequency;
      last_ff <= {last_ff[PIPE_LAT-2:0], req_payload.last_sample_in};
   end

   // three lanes, one per resonance
   for (genvar k = 0; k < TERM_N; k++) begin : g_term
      dsi_term u_term (
         .clock    (clock),
         .w        (w_ff),
         .l_mag    (coefs[k+TERM_N].mag),
         .b_coef   (coefs[k]),
         .term     (term[k]),
         .den_zero (dzero[k])
      );
   end

   // permittivity sum over two stages, then range check
   always_ff @(posedge clock) begin
      s01_ff   <= term[0] + term[1];
      t2p_ff   <= term[2] + ONE_Q30;
      zero1_ff <= |dzero;
      er_ff    <= s01_ff + t2p_ff;
      zero2_ff <= zero1_ff;
      tag_ff.invalid  <= zero2_ff || (er_ff <= 0);
      tag_ff.saturate <= er_ff >= SAT_LIM;
      x_ff     <= {er_ff[33:0], 30'b0};
   end

   dsi_sqrt u_sqrt (
      .clock   (clock),
      .x       (x_ff),
      .tag_in  (tag_ff),
      .root    (root),
      .tag_out (tag_out)
   );

   // result register: invalid reads as zero, index of four or more saturates
   always_ff @(posedge clock) begin
      rsp_ff.refractive_index <= tag_out.invalid  ? '0 :
                                 tag_out.saturate ? '1 : root;
      rsp_ff.index_invalid    <= tag_out.invalid;
      rsp_ff.last_sample_out  <= last_ff[PIPE_LAT-1];
   end

   assign rsp_strobe  = vld_ff[PIPE_LAT];
   assign rsp_payload = rsp_ff;

endmodule
